/* sv/adam_pkg.sv */
package adam_pkg;

    localparam int DATA_W = 48;
    localparam int REG_W  = 32;
    localparam int IDX_W  = 10;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W = 4;

    localparam logic [DATA_W-1:0] MAX_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MAX_NEG = 48'h8000_0000_0000;
    localparam logic [62:0]       QUOT_CAP = 63'h4000_0000_0000_0000;
    localparam logic [REG_W:0]    ONE_Q32 = 33'h1_0000_0000;

    localparam logic [REG_W-1:0] STEP_SIZE_RESET    = 32'd4294967;
    localparam logic [REG_W-1:0] FIRST_DECAY_RESET  = 32'd3865470566;
    localparam logic [REG_W-1:0] SECOND_DECAY_RESET = 32'd4290672329;
    localparam logic [REG_W-1:0] EPSILON_RESET      = 32'd429;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DECAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_DECAY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 2'd3;

    // Datapath steps run on the shared multi-cycle engine.
    localparam logic [STEP_W-1:0] STEP_RATE_SQRT = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RATE_MUL  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_RATE_DIV  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_PM        = 4'd3;
    localparam logic [STEP_W-1:0] STEP_PG        = 4'd4;
    localparam logic [STEP_W-1:0] STEP_T         = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SQ        = 4'd6;
    localparam logic [STEP_W-1:0] STEP_V         = 4'd7;
    localparam logic [STEP_W-1:0] STEP_ROOT      = 4'd8;
    localparam logic [STEP_W-1:0] STEP_QUOT      = 4'd9;
    localparam logic [STEP_W-1:0] STEP_SCALE     = 4'd10;
    localparam logic [STEP_W-1:0] STEP_POW1      = 4'd11;
    localparam logic [STEP_W-1:0] STEP_POW2      = 4'd12;

    typedef struct packed {
        logic [IDX_W-1:0]         element_index;
        logic signed [DATA_W-1:0] gradient;
        logic                     last_element;
    } grad_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] update_value;
        logic                     last_out;
    } upd_item_t;

    typedef struct packed {
        logic              accept;
        logic              ram_read;
        logic              start;
        logic [STEP_W-1:0] step;
        logic              load_out;
        logic              clear;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rate_valid;
        logic in_range;
        logic skip_quot;
        logic last;
        logic clear_done;
    } dp_status_t;

endpackage

/* sv/adam_ram.sv */
module adam_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/adam_dp.sv */
module adam_dp #(
    parameter int ELEMENT_COUNT = 1024,
    parameter int FRACTION_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  adam_pkg::dp_cmd_t                   cmd,
    output adam_pkg::dp_status_t                status,
    input  adam_pkg::grad_item_t                grad,
    output adam_pkg::upd_item_t                 upd,
    input  logic                                cfg_wr_en,
    input  logic [adam_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [adam_pkg::REG_W-1:0]          cfg_data
);

    localparam int AW     = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
    localparam int DW     = adam_pkg::DATA_W + FRACTION_BITS;
    localparam int RAD0   = (FRACTION_BITS + 47 > 65) ? FRACTION_BITS + 47 : 65;
    localparam int RW     = (RAD0 + 1) / 2;
    localparam int RADW   = 2 * RW;
    localparam int CW     = $clog2(DW + 1);
    localparam int SH_UP  = (FRACTION_BITS >= 32) ? FRACTION_BITS - 32 : 0;
    localparam int SH_DN  = (FRACTION_BITS >= 32) ? 0 : 32 - FRACTION_BITS;
    localparam logic signed [49:0] SAT_HI = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SAT_LO = -50'sh0_8000_0000_0000;

    // configuration and per-matrix state
    logic [31:0] step_size_reg, first_decay_reg, second_decay_reg, epsilon_reg;
    logic [31:0] pow1_reg, pow2_reg;
    logic [47:0] rate_reg;
    logic        rate_valid_reg;

    // transaction payload
    logic [9:0]  idx_reg;
    logic [47:0] grad_reg;
    logic        last_reg;

    // engine
    logic                    busy_reg;
    logic [CW-1:0]           cnt_reg;
    logic [3:0]              step_reg;
    logic [63:0]             mul_a_reg, mul_b_reg;
    logic [127:0]            acc_reg;
    logic [RADW-1:0]         rad_reg;
    logic [RW+1:0]           srem_reg;
    logic [RW-1:0]           root_reg;
    logic [DW-1:0]           num_reg;
    logic [47:0]             drem_reg;
    logic [47:0]             den_op_reg;

    // intermediate results
    logic [47:0] pm_reg, m_new_reg, t_reg, sq_reg, v_new_reg, den_reg, scaled_reg;
    logic [62:0] q_reg;
    logic [47:0] out_val_reg;
    logic        out_last_reg;

    logic [AW-1:0] clr_cnt_reg;

    logic [AW-1:0]  addr;
    logic [16:0]    idx_ext;
    logic           in_range;
    logic [47:0]    m_rdata, v_rdata;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [47:0]    m_wdata, v_wdata;

    logic           is_sqrt, is_div, done;
    logic [CW-1:0]  last_cnt;

    logic [47:0]    gmag, mmag_old, mnew_mag, lim, epsq, eps_dn, v_calc, pg;
    logic           g_neg, m_neg_old, mnew_neg;
    logic [63:0]    acc_hi32;
    logic [127:0]   acc_shf;
    logic [48:0]    v_sum;
    logic [48:0]    den_sum;
    logic signed [49:0] pm_s, pg_s, ms;
    logic [47:0]    ms_sat;
    logic [DW-1:0]  rate_dn;
    logic [47:0]    rate_fix;
    logic [31:0]    part_a, part_b;
    logic [63:0]    part;
    logic [6:0]     part_sh;
    logic [RW+1:0]  srem_next, strial;
    logic [48:0]    drem_next;
    logic [47:0]    qmag, out_val;

    assign idx_ext  = {7'd0, idx_reg};
    assign addr     = idx_ext[AW-1:0];
    assign in_range = idx_ext < 17'(ELEMENT_COUNT);

    assign ram_we    = cmd.clear || (done && step_reg == adam_pkg::STEP_V);
    assign ram_waddr = cmd.clear ? clr_cnt_reg : addr;
    assign m_wdata   = cmd.clear ? 48'd0 : m_new_reg;
    assign v_wdata   = cmd.clear ? 48'd0 : v_calc;

    adam_ram #(.WIDTH(48), .DEPTH(ELEMENT_COUNT)) u_first_moment (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (m_wdata),
        .rd_en   (cmd.ram_read),
        .rd_addr (addr),
        .rd_data (m_rdata)
    );

    adam_ram #(.WIDTH(48), .DEPTH(ELEMENT_COUNT)) u_second_moment (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (v_wdata),
        .rd_en   (cmd.ram_read),
        .rd_addr (addr),
        .rd_data (v_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // engine control
    always_comb
    begin
        is_sqrt = (step_reg == adam_pkg::STEP_RATE_SQRT) || (step_reg == adam_pkg::STEP_ROOT);
        is_div  = (step_reg == adam_pkg::STEP_RATE_DIV) || (step_reg == adam_pkg::STEP_QUOT);
        if (is_sqrt)
        begin
            last_cnt = CW'(RW);
        end
        else if (is_div)
        begin
            last_cnt = CW'(DW);
        end
        else
        begin
            last_cnt = CW'(4);
        end
        done = busy_reg && (cnt_reg == last_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            step_reg <= adam_pkg::STEP_RATE_SQRT;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            step_reg <= cmd.step;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // operand decode
    always_comb
    begin
        g_neg     = grad_reg[47];
        gmag      = g_neg ? (48'd0 - grad_reg) : grad_reg;
        m_neg_old = m_rdata[47];
        mmag_old  = m_neg_old ? (48'd0 - m_rdata) : m_rdata;
        mnew_neg  = m_new_reg[47];
        mnew_mag  = mnew_neg ? (48'd0 - m_new_reg) : m_new_reg;
        lim       = mnew_neg ? adam_pkg::MAX_NEG : adam_pkg::MAX_POS;
        eps_dn    = {16'd0, epsilon_reg} >> SH_DN;
        epsq      = (eps_dn > (adam_pkg::MAX_POS >> SH_UP)) ? adam_pkg::MAX_POS
                                                            : (eps_dn << SH_UP);
        acc_hi32  = acc_reg[95:32];
        acc_shf   = acc_reg >> FRACTION_BITS;
        pg        = acc_hi32[47:0];
        pm_s      = m_neg_old ? -$signed({2'b00, pm_reg}) : $signed({2'b00, pm_reg});
        pg_s      = g_neg ? -$signed({2'b00, pg}) : $signed({2'b00, pg});
        ms        = pm_s + pg_s;
        if (ms > SAT_HI)
        begin
            ms_sat = adam_pkg::MAX_POS;
        end
        else if (ms < SAT_LO)
        begin
            ms_sat = adam_pkg::MAX_NEG;
        end
        else
        begin
            ms_sat = ms[47:0];
        end
        v_sum  = {1'b0, acc_hi32[47:0]} + {1'b0, sq_reg};
        v_calc = (v_sum > {1'b0, adam_pkg::MAX_POS}) ? adam_pkg::MAX_POS : v_sum[47:0];
        den_sum = {1'b0, 48'(root_reg)} + {1'b0, epsq};
        rate_dn = num_reg >> SH_DN;
        rate_fix = (rate_dn > DW'(adam_pkg::MAX_POS >> SH_UP)) ? adam_pkg::MAX_POS
                                                              : rate_dn[47:0] << SH_UP;
    end

    // one iteration of the engine
    always_comb
    begin
        part_a    = cnt_reg[1] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        part_b    = cnt_reg[0] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        part      = part_a * part_b;
        part_sh   = {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0], 5'd0};
        srem_next = {srem_reg[RW-1:0], rad_reg[RADW-1:RADW-2]};
        strial    = {root_reg, 2'b01};
        drem_next = {drem_reg, num_reg[DW-1]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg   <= '0;
            srem_reg  <= '0;
            root_reg  <= '0;
            drem_reg  <= '0;
            case (cmd.step)
                adam_pkg::STEP_RATE_SQRT:
                begin
                    rad_reg <= RADW'({adam_pkg::ONE_Q32 - {1'b0, pow2_reg}, 32'd0});
                end
                adam_pkg::STEP_RATE_MUL:
                begin
                    mul_a_reg <= {32'd0, step_size_reg};
                    mul_b_reg <= 64'(root_reg);
                end
                adam_pkg::STEP_RATE_DIV:
                begin
                    num_reg    <= DW'(acc_reg[63:0]);
                    den_op_reg <= 48'(adam_pkg::ONE_Q32 - {1'b0, pow1_reg});
                end
                adam_pkg::STEP_PM:
                begin
                    mul_a_reg <= {16'd0, mmag_old};
                    mul_b_reg <= {32'd0, first_decay_reg};
                end
                adam_pkg::STEP_PG:
                begin
                    mul_a_reg <= {16'd0, gmag};
                    mul_b_reg <= 64'(adam_pkg::ONE_Q32 - {1'b0, first_decay_reg});
                end
                adam_pkg::STEP_T:
                begin
                    mul_a_reg <= {16'd0, gmag};
                    mul_b_reg <= 64'(adam_pkg::ONE_Q32 - {1'b0, second_decay_reg});
                end
                adam_pkg::STEP_SQ:
                begin
                    mul_a_reg <= {16'd0, t_reg};
                    mul_b_reg <= {16'd0, gmag};
                end
                adam_pkg::STEP_V:
                begin
                    mul_a_reg <= {17'd0, v_rdata[46:0]};
                    mul_b_reg <= {32'd0, second_decay_reg};
                end
                adam_pkg::STEP_ROOT:
                begin
                    rad_reg <= RADW'(v_new_reg) << FRACTION_BITS;
                end
                adam_pkg::STEP_QUOT:
                begin
                    num_reg    <= DW'(mnew_mag) << FRACTION_BITS;
                    den_op_reg <= den_reg;
                end
                adam_pkg::STEP_SCALE:
                begin
                    mul_a_reg <= {1'b0, q_reg};
                    mul_b_reg <= {16'd0, rate_reg};
                end
                adam_pkg::STEP_POW1:
                begin
                    mul_a_reg <= {32'd0, pow1_reg};
                    mul_b_reg <= {32'd0, first_decay_reg};
                end
                adam_pkg::STEP_POW2:
                begin
                    mul_a_reg <= {32'd0, pow2_reg};
                    mul_b_reg <= {32'd0, second_decay_reg};
                end
                default:
                begin
                    mul_a_reg <= '0;
                end
            endcase
        end
        else if (busy_reg && !done)
        begin
            if (is_sqrt)
            begin
                rad_reg <= rad_reg << 2;
                if (srem_next >= strial)
                begin
                    srem_reg <= srem_next - strial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_next;
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
            end
            else if (is_div)
            begin
                if (drem_next >= {1'b0, den_op_reg})
                begin
                    drem_reg <= 48'(drem_next - {1'b0, den_op_reg});
                    num_reg  <= {num_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_next[47:0];
                    num_reg  <= {num_reg[DW-2:0], 1'b0};
                end
            end
            else
            begin
                acc_reg <= acc_reg + ({64'd0, part} << part_sh);
            end
        end
    end

    // per-element results and output register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg  <= grad.element_index;
            grad_reg <= grad.gradient;
            last_reg <= grad.last_element;
        end
        if (done)
        begin
            case (step_reg)
                adam_pkg::STEP_PM:   pm_reg    <= acc_hi32[47:0];
                adam_pkg::STEP_PG:   m_new_reg <= ms_sat;
                adam_pkg::STEP_T:    t_reg     <= acc_hi32[47:0];
                adam_pkg::STEP_SQ:
                begin
                    sq_reg <= (acc_shf > 128'(adam_pkg::MAX_POS)) ? adam_pkg::MAX_POS
                                                                   : acc_shf[47:0];
                end
                adam_pkg::STEP_V:    v_new_reg <= v_calc;
                adam_pkg::STEP_ROOT: den_reg   <= den_sum[47:0];
                adam_pkg::STEP_QUOT:
                begin
                    q_reg <= (num_reg > DW'(adam_pkg::QUOT_CAP)) ? adam_pkg::QUOT_CAP
                                                                : num_reg[62:0];
                end
                adam_pkg::STEP_SCALE:
                begin
                    scaled_reg <= (acc_shf > 128'(lim)) ? lim : acc_shf[47:0];
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.load_out)
        begin
            out_val_reg  <= out_val;
            out_last_reg <= last_reg;
        end
    end

    always_comb
    begin
        qmag = (den_reg == 48'd0) ? lim : scaled_reg;
        if (!in_range || mnew_mag == 48'd0)
        begin
            out_val = 48'd0;
        end
        else
        begin
            out_val = mnew_neg ? (48'd0 - qmag) : qmag;
        end
    end

    // registers, decay powers and the corrected rate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg    <= adam_pkg::STEP_SIZE_RESET;
            first_decay_reg  <= adam_pkg::FIRST_DECAY_RESET;
            second_decay_reg <= adam_pkg::SECOND_DECAY_RESET;
            epsilon_reg      <= adam_pkg::EPSILON_RESET;
            pow1_reg         <= adam_pkg::FIRST_DECAY_RESET;
            pow2_reg         <= adam_pkg::SECOND_DECAY_RESET;
            rate_reg         <= '0;
            rate_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    adam_pkg::REG_STEP_SIZE:
                    begin
                        step_size_reg  <= cfg_data;
                        rate_valid_reg <= 1'b0;
                    end
                    adam_pkg::REG_FIRST_DECAY:
                    begin
                        first_decay_reg <= cfg_data;
                        pow1_reg        <= cfg_data;
                        rate_valid_reg  <= 1'b0;
                    end
                    adam_pkg::REG_SECOND_DECAY:
                    begin
                        second_decay_reg <= cfg_data;
                        pow2_reg         <= cfg_data;
                        rate_valid_reg   <= 1'b0;
                    end
                    adam_pkg::REG_EPSILON:
                    begin
                        epsilon_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (done)
            begin
                case (step_reg)
                    adam_pkg::STEP_RATE_DIV:
                    begin
                        rate_reg       <= rate_fix;
                        rate_valid_reg <= 1'b1;
                    end
                    adam_pkg::STEP_POW1:
                    begin
                        pow1_reg <= acc_hi32[31:0];
                    end
                    adam_pkg::STEP_POW2:
                    begin
                        pow2_reg       <= acc_hi32[31:0];
                        rate_valid_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        status.busy       = busy_reg;
        status.done       = done;
        status.rate_valid = rate_valid_reg;
        status.in_range   = in_range;
        status.skip_quot  = (mnew_mag == 48'd0) || (den_reg == 48'd0);
        status.last       = last_reg;
        status.clear_done = (clr_cnt_reg == AW'(ELEMENT_COUNT - 1));
        upd.update_value  = out_val_reg;
        upd.last_out      = out_last_reg;
    end

endmodule

/* sv/adam_ctrl.sv */
module adam_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  grad_valid,
    output logic                  grad_stall,
    output logic                  upd_valid,
    input  logic                  upd_stall,
    output adam_pkg::dp_cmd_t     cmd,
    input  adam_pkg::dp_status_t  status
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_READ  = 5'd2;
    localparam logic [4:0] S_RSQRT = 5'd3;
    localparam logic [4:0] S_RMUL  = 5'd4;
    localparam logic [4:0] S_RDIV  = 5'd5;
    localparam logic [4:0] S_PM    = 5'd6;
    localparam logic [4:0] S_PG    = 5'd7;
    localparam logic [4:0] S_T     = 5'd8;
    localparam logic [4:0] S_SQ    = 5'd9;
    localparam logic [4:0] S_V     = 5'd10;
    localparam logic [4:0] S_ROOT  = 5'd11;
    localparam logic [4:0] S_CHECK = 5'd12;
    localparam logic [4:0] S_QUOT  = 5'd13;
    localparam logic [4:0] S_SCALE = 5'd14;
    localparam logic [4:0] S_POW1  = 5'd15;
    localparam logic [4:0] S_POW2  = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       eng_state;
    logic [3:0] step;
    logic       accept, load_out;
    logic [4:0] elem_next, tail_next;

    assign accept     = grad_valid && (state_reg == S_IDLE);
    assign grad_stall = (state_reg != S_IDLE);
    assign upd_valid  = out_valid_reg;
    assign load_out   = (state_reg == S_OUT) && (!out_valid_reg || !upd_stall);
    assign tail_next  = status.last ? S_POW1 : S_OUT;
    assign elem_next  = status.in_range ? S_PM : tail_next;

    always_comb
    begin
        eng_state = 1'b1;
        step      = adam_pkg::STEP_RATE_SQRT;
        unique case (state_reg)
            S_RSQRT: step = adam_pkg::STEP_RATE_SQRT;
            S_RMUL:  step = adam_pkg::STEP_RATE_MUL;
            S_RDIV:  step = adam_pkg::STEP_RATE_DIV;
            S_PM:    step = adam_pkg::STEP_PM;
            S_PG:    step = adam_pkg::STEP_PG;
            S_T:     step = adam_pkg::STEP_T;
            S_SQ:    step = adam_pkg::STEP_SQ;
            S_V:     step = adam_pkg::STEP_V;
            S_ROOT:  step = adam_pkg::STEP_ROOT;
            S_QUOT:  step = adam_pkg::STEP_QUOT;
            S_SCALE: step = adam_pkg::STEP_SCALE;
            S_POW1:  step = adam_pkg::STEP_POW1;
            S_POW2:  step = adam_pkg::STEP_POW2;
            default: eng_state = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (status.clear_done) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_READ;
            S_READ:  state_next = status.rate_valid ? elem_next : S_RSQRT;
            S_RSQRT: if (status.done) state_next = S_RMUL;
            S_RMUL:  if (status.done) state_next = S_RDIV;
            S_RDIV:  if (status.done) state_next = elem_next;
            S_PM:    if (status.done) state_next = S_PG;
            S_PG:    if (status.done) state_next = S_T;
            S_T:     if (status.done) state_next = S_SQ;
            S_SQ:    if (status.done) state_next = S_V;
            S_V:     if (status.done) state_next = S_ROOT;
            S_ROOT:  if (status.done) state_next = S_CHECK;
            S_CHECK: state_next = status.skip_quot ? tail_next : S_QUOT;
            S_QUOT:  if (status.done) state_next = S_SCALE;
            S_SCALE: if (status.done) state_next = tail_next;
            S_POW1:  if (status.done) state_next = S_POW2;
            S_POW2:  if (status.done) state_next = S_OUT;
            S_OUT:   if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !upd_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd.accept   = accept;
        cmd.ram_read = (state_reg == S_READ);
        cmd.start    = eng_state && !status.busy;
        cmd.step     = step;
        cmd.load_out = load_out;
        cmd.clear    = (state_reg == S_CLEAR);
    end

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_READ)
        else $error("accepted transaction did not move to the memory read");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        grad_valid && !grad_stall |-> state_reg != S_CLEAR)
        else $error("transaction accepted during the clearing pass");

    a_rate_before_element: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && cmd.step == adam_pkg::STEP_PM |-> status.rate_valid)
        else $error("element update started without a corrected rate");

endmodule

/* sv/adam_optimizer_update.sv */
// Each element runs its steps in turn on the shared engine, whose square root and
// divider are bit-serial, with DW = FRACTION_BITS + 48 the divider width and
// RW = ceil(max(FRACTION_BITS + 47, 65) / 2) the root width. The first element of a
// matrix first runs the rate correction, and a last element then updates the decay
// powers. One transaction at a time. After reset a clearing pass zeroes both
// moment memories.
module adam_optimizer_update #(
    parameter int ELEMENT_COUNT = 1024,
    parameter int FRACTION_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              grad_valid,
    output logic                              grad_stall,
    input  adam_pkg::grad_item_t              grad,
    output logic                              upd_valid,
    input  logic                              upd_stall,
    output adam_pkg::upd_item_t               upd,
    input  logic                              cfg_wr_en,
    input  logic [adam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adam_pkg::REG_W-1:0]        cfg_data
);

    adam_pkg::dp_cmd_t    cmd;
    adam_pkg::dp_status_t status;

    adam_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .grad_valid (grad_valid),
        .grad_stall (grad_stall),
        .upd_valid  (upd_valid),
        .upd_stall  (upd_stall),
        .cmd        (cmd),
        .status     (status)
    );

    adam_dp #(
        .ELEMENT_COUNT (ELEMENT_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .grad      (grad),
        .upd       (upd),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* test/adam_update_checker.sv */
module adam_update_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           grad_valid,
    input  logic                           grad_stall,
    input  adam_pkg::grad_item_t           grad,
    input  logic                           upd_valid,
    input  logic                           upd_stall,
    input  adam_pkg::upd_item_t            upd,
    input  logic                           cfg_wr_en,
    input  logic [adam_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [adam_pkg::REG_W-1:0]     cfg_data,
    output int                             errors,
    output int                             pending,
    output int                             checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ELEMS = 1024;
    localparam int FRAC = 32;

    logic [31:0] alpha, beta1, beta2, eps;
    logic [31:0] beta1_pow, beta2_pow;
    logic [47:0] first_mom [NUM_ELEMS];
    logic [47:0] second_mom [NUM_ELEMS];
    logic [47:0] alpha_t;
    logic        alpha_t_ok;
    adam_pkg::upd_item_t expected_updates [$];

    function automatic logic [63:0] int_sqrt(input logic [127:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x)
                r = c;
        end
        return r;
    endfunction

    // Magnitude times a Q1.32 fraction, truncated.
    function automatic logic [63:0] scale_q32(input logic [63:0] mag, input logic [32:0] frac);
        logic [127:0] p;
        p = {64'd0, mag} * {95'd0, frac};
        return p[95:32];
    endfunction

    function automatic logic [47:0] magnitude(input logic [47:0] x);
        return x[47] ? (48'd0 - x) : x;
    endfunction

    // Bias-corrected learning rate from the current decay powers.
    function automatic void refresh_rate();
        logic [32:0]  om2;
        logic [63:0]  root;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [63:0]  q;
        om2  = adam_pkg::ONE_Q32 - {1'b0, beta2_pow};
        root = int_sqrt({63'd0, om2, 32'd0});
        num  = {32'd0, alpha} * root;
        den  = adam_pkg::ONE_Q32 - {1'b0, beta1_pow};
        q    = num / den;
        alpha_t    = (q > {16'd0, adam_pkg::MAX_POS}) ? adam_pkg::MAX_POS : q[47:0];
        alpha_t_ok = 1'b1;
    endfunction

    function automatic adam_pkg::upd_item_t predict_update(input adam_pkg::grad_item_t g);
        adam_pkg::upd_item_t res;
        logic [47:0]  gmag, mmag, lim;
        logic [63:0]  pm, pg, t, vsum, root, den, qmag;
        logic [127:0] sqw, quot, prod;
        logic signed [65:0] msum;
        logic [63:0]  sq_term;
        logic [63:0]  pw1, pw2;
        int           idx;
        idx = g.element_index;
        if (!alpha_t_ok)
            refresh_rate();
        gmag = magnitude(g.gradient);
        mmag = magnitude(first_mom[idx]);
        pm = scale_q32({16'd0, mmag}, {1'b0, beta1});
        pg = scale_q32({16'd0, gmag}, adam_pkg::ONE_Q32 - {1'b0, beta1});
        msum = (first_mom[idx][47] ? -$signed({2'b0, pm}) : $signed({2'b0, pm}))
             + (g.gradient[47] ? -$signed({2'b0, pg}) : $signed({2'b0, pg}));
        if (msum > $signed({18'd0, adam_pkg::MAX_POS}))
            msum = $signed({18'd0, adam_pkg::MAX_POS});
        if (msum < -$signed({18'd0, adam_pkg::MAX_NEG}))
            msum = -$signed({18'd0, adam_pkg::MAX_NEG});
        first_mom[idx] = msum[47:0];

        t = scale_q32({16'd0, gmag}, adam_pkg::ONE_Q32 - {1'b0, beta2});
        sqw = ({64'd0, t} * {80'd0, gmag}) >> FRAC;
        sq_term = (sqw > {80'd0, adam_pkg::MAX_POS}) ? {16'd0, adam_pkg::MAX_POS}
                                                     : sqw[63:0];
        vsum = scale_q32({17'd0, second_mom[idx][46:0]}, {1'b0, beta2}) + sq_term;
        if (vsum > {16'd0, adam_pkg::MAX_POS})
            vsum = {16'd0, adam_pkg::MAX_POS};
        second_mom[idx] = vsum[47:0];

        root = int_sqrt({64'd0, vsum} << FRAC);
        den  = root + {32'd0, eps};
        mmag = magnitude(first_mom[idx]);
        res.last_out = g.last_element;
        if (mmag == 0) begin
            res.update_value = '0;
        end else begin
            lim = first_mom[idx][47] ? adam_pkg::MAX_NEG : adam_pkg::MAX_POS;
            if (den == 0) begin
                qmag = {16'd0, lim};
            end else begin
                quot = ({80'd0, mmag} << FRAC) / {64'd0, den};
                if (quot > {65'd0, adam_pkg::QUOT_CAP})
                    quot = {65'd0, adam_pkg::QUOT_CAP};
                prod = (quot * {80'd0, alpha_t}) >> FRAC;
                qmag = (prod > {80'd0, lim}) ? {16'd0, lim} : prod[63:0];
            end
            res.update_value = first_mom[idx][47] ? (48'd0 - qmag[47:0]) : qmag[47:0];
        end
        if (g.last_element) begin
            pw1        = {32'd0, beta1_pow} * {32'd0, beta1};
            pw2        = {32'd0, beta2_pow} * {32'd0, beta2};
            beta1_pow  = pw1[63:32];
            beta2_pow  = pw2[63:32];
            alpha_t_ok = 1'b0;
        end
        return res;
    endfunction

    assign pending = expected_updates.size();

    always @(posedge clk or negedge rst_n) begin
        adam_pkg::upd_item_t want;
        if (!rst_n) begin
            alpha      = adam_pkg::STEP_SIZE_RESET;
            beta1      = adam_pkg::FIRST_DECAY_RESET;
            beta2      = adam_pkg::SECOND_DECAY_RESET;
            eps        = adam_pkg::EPSILON_RESET;
            beta1_pow  = adam_pkg::FIRST_DECAY_RESET;
            beta2_pow  = adam_pkg::SECOND_DECAY_RESET;
            alpha_t    = '0;
            alpha_t_ok = 1'b0;
            for (int i = 0; i < NUM_ELEMS; i++) begin
                first_mom[i]  = '0;
                second_mom[i] = '0;
            end
            errors  <= 0;
            checked <= 0;
            expected_updates.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    adam_pkg::REG_STEP_SIZE: begin
                        alpha = cfg_data;
                        alpha_t_ok = 1'b0;
                    end
                    adam_pkg::REG_FIRST_DECAY: begin
                        beta1 = cfg_data;
                        beta1_pow = cfg_data;
                        alpha_t_ok = 1'b0;
                    end
                    adam_pkg::REG_SECOND_DECAY: begin
                        beta2 = cfg_data;
                        beta2_pow = cfg_data;
                        alpha_t_ok = 1'b0;
                    end
                    adam_pkg::REG_EPSILON: eps = cfg_data;
                    default: ;
                endcase
            end
            if (grad_valid && !grad_stall)
                expected_updates.push_back(predict_update(grad));
            if (upd_valid && !upd_stall) begin
                checked <= checked + 1;
                if (expected_updates.size() == 0) begin
                    if (errors < 10)
                        $display("%0t checker: update with nothing expected: value %h last %b",
                                 $realtime, upd.update_value, upd.last_out);
                    errors <= errors + 1;
                end else begin
                    want = expected_updates.pop_front();
                    if (upd.update_value !== want.update_value || upd.last_out !== want.last_out)
                    begin
                        if (errors < 10)
                            $display("%0t checker: mismatch: expected value %h last %b, got %h %b",
                                     $realtime, want.update_value, want.last_out,
                                     upd.update_value, upd.last_out);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           clk;
    logic                           rst_n;
    logic                           grad_valid;
    logic                           grad_stall;
    adam_pkg::grad_item_t           grad;
    logic                           upd_valid;
    logic                           upd_stall;
    adam_pkg::upd_item_t            upd;
    logic                           cfg_wr_en;
    logic [adam_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [adam_pkg::REG_W-1:0]     cfg_data;
    int                             errors;
    int                             pending;
    int                             checked;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_output;
    int  sent;
    int  settings;

    adam_optimizer_update uut (
        .clk(clk), .rst_n(rst_n),
        .grad_valid(grad_valid), .grad_stall(grad_stall), .grad(grad),
        .upd_valid(upd_valid), .upd_stall(upd_stall), .upd(upd),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    adam_update_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .grad_valid(grad_valid), .grad_stall(grad_stall), .grad(grad),
        .upd_valid(upd_valid), .upd_stall(upd_stall), .upd(upd),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .checked(checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("tb: done, errors");
        $finish;
    end

    // Receiver side: random stalls, or a long hold-off when requested.
    initial begin
        upd_stall = 1'b0;
        forever begin
            @(negedge clk);
            upd_stall = hold_output || ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_gradient(input logic [9:0] idx, input logic [47:0] g, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            grad_valid = 1'b0;
            @(negedge clk);
        end
        grad_valid         = 1'b1;
        grad.element_index = idx;
        grad.gradient      = g;
        grad.last_element  = last;
        do
            @(posedge clk);
        while (grad_stall);
        @(negedge clk);
        grad_valid = 1'b0;
        sent++;
    endtask

    task automatic write_reg(input logic [adam_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Wait for every update to come back, then let the power update settle.
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic load_settings(input logic [31:0] a, input logic [31:0] b1,
                                 input logic [31:0] b2, input logic [31:0] e);
        drain();
        write_reg(adam_pkg::REG_STEP_SIZE, a);
        write_reg(adam_pkg::REG_FIRST_DECAY, b1);
        write_reg(adam_pkg::REG_SECOND_DECAY, b2);
        write_reg(adam_pkg::REG_EPSILON, e);
        settings++;
    endtask

    function automatic logic [31:0] rand_reg();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'hF000_0000 | $urandom_range(32'h0FFF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] rand_gradient();
        logic [47:0] g;
        case ($urandom_range(7))
            0: g = adam_pkg::MAX_POS;
            1: g = adam_pkg::MAX_NEG;
            2: g = '0;
            3, 4: g = 48'({$urandom, $urandom});
            default: begin
                g = {16'd0, $urandom} << $urandom_range(2);
                if ($urandom_range(1))
                    g = 48'd0 - g;
            end
        endcase
        return g;
    endfunction

    // A matrix pass: a run of elements ending in a flagged last element.
    task automatic send_matrix();
        int          len;
        logic [9:0]  base;
        logic [9:0]  idx;
        len  = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
        base = 10'($urandom);
        for (int i = 0; i < len; i++) begin
            idx = ($urandom_range(4) == 0) ? 10'($urandom) : base + 10'(i);
            send_gradient(idx, rand_gradient(), i == len - 1);
        end
    endtask

    task automatic random_chunk(input int count);
        int start;
        start = sent;
        while (sent - start < count) begin
            if ($urandom_range(9) == 0)
                send_gradient(10'($urandom), rand_gradient(), 1'($urandom));
            else
                send_matrix();
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        grad_valid     = 1'b0;
        grad           = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = adam_pkg::REG_STEP_SIZE;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_output    = 1'b0;
        sent           = 0;
        settings       = 1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: field extremes, repeated element, both flag values.
        send_gradient(10'd0, adam_pkg::MAX_POS, 1'b0);
        send_gradient(10'd1023, adam_pkg::MAX_NEG, 1'b0);
        send_gradient(10'd5, 48'd0, 1'b0);
        send_gradient(10'd0, adam_pkg::MAX_POS, 1'b0);
        send_gradient(10'd0, 48'h0000_0001_0000, 1'b1);
        send_gradient(10'd1023, 48'hFFFF_FFFF_0000, 1'b1);
        send_gradient(10'd2, 48'h0000_0000_0001, 1'b1);

        // Zero denominator: no decay on the mean, full decay on the variance, no epsilon.
        load_settings(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_gradient(10'd100, 48'd7, 1'b0);
        send_gradient(10'd101, -48'sd9, 1'b0);
        send_gradient(10'd102, 48'd0, 1'b1);
        send_gradient(10'd100, adam_pkg::MAX_POS, 1'b1);

        load_settings(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_gradient(10'd200, adam_pkg::MAX_NEG, 1'b0);
        send_gradient(10'd200, adam_pkg::MAX_POS, 1'b1);
        send_gradient(10'd201, 48'h5555_5555_5555, 1'b1);

        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_gradient(10'd300, 48'hAAAA_AAAA_AAAA, 1'b0);
        send_gradient(10'd300, adam_pkg::MAX_POS, 1'b1);
        send_gradient(10'd301, 48'h0000_0100_0000, 1'b1);

        for (int chunk = 0; chunk < 6; chunk++) begin
            if (chunk == 0)
                load_settings(adam_pkg::STEP_SIZE_RESET, adam_pkg::FIRST_DECAY_RESET,
                              adam_pkg::SECOND_DECAY_RESET, adam_pkg::EPSILON_RESET);
            else
                load_settings(rand_reg(), rand_reg(), rand_reg(), rand_reg());
            send_idle_pct  = (chunk < 2) ? 38 : (chunk < 4) ? 80 : 0;
            recv_stall_pct = (chunk < 2) ? 80 : (chunk < 4) ? 38 : 0;
            if (chunk == 5) begin
                // Hold the output off long enough that the input backs up.
                fork
                    begin
                        hold_output = 1'b1;
                        repeat (3000) @(negedge clk);
                        hold_output = 1'b0;
                    end
                    random_chunk(315);
                join
            end else begin
                random_chunk(315);
            end
        end

        drain();
        repeat (400) @(negedge clk);
        $display("tb: %0d gradient transactions sent, %0d updates compared, %0d register settings",
                 sent, checked, settings);
        $display("tb: covered field extremes, zero denominator, stalls, gaps and a long hold-off");
        if (errors == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
